// File: rtl/msb_first_bit_packer_top_assert.svh
// assertion macros for the bit packer
`ifndef MSB_FIRST_BIT_PACKER_TOP_ASSERT_SVH
`define MSB_FIRST_BIT_PACKER_TOP_ASSERT_SVH

// same-cycle implication
`define BP_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("bit packer check failed");

// next-cycle implication
`define BP_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("bit packer check failed");

`endif

// File: rtl/bp_pkg.sv
// ----------------------------------------------------------------------------
// bp_pkg
// shared types and constants of the msb-first bit packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bp_pkg;

    localparam int WORD_BITS = 32;
    localparam int CNT_W     = 6;

    // input command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_FLUSH,
        OP_CLEAR
    } t_op_kind;

    // decoded operation, count saturated and code masked
    typedef struct packed {
        t_op_kind               kind;
        logic [CNT_W-1:0]       bits;
        logic [WORD_BITS-1:0]   code;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic             empty;
        logic [1:0]       out_count;
        logic             out_push;
        logic [CNT_W-1:0] free_bits;
    } t_back_status;

endpackage

// File: rtl/bp_front.sv
// ----------------------------------------------------------------------------
// bp_front
// decodes incoming commands into packer operations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bp_front
    import bp_pkg::*;
(
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [1:0]           i_command,
    input  logic [CNT_W-1:0]     i_bit_count,
    input  logic [WORD_BITS-1:0] i_code_bits,
    output logic                 o_op_push,
    output t_op                  o_op
);

    logic [CNT_W-1:0]     w_bits;
    logic [WORD_BITS-1:0] w_mask;
    logic                 w_keep;

    always_comb begin
        w_bits = (i_bit_count > CNT_W'(WORD_BITS)) ? CNT_W'(WORD_BITS) : i_bit_count;
        if (w_bits == CNT_W'(WORD_BITS)) begin
            w_mask = '1;
        end else begin
            w_mask = (WORD_BITS'(1) << w_bits) - WORD_BITS'(1);
        end

        o_op.bits = w_bits;
        o_op.code = i_code_bits & w_mask;
        o_op.kind = OP_PUT;
        w_keep    = 1'b0;
        unique case (i_command)
            CMD_PUT: begin
                // zero-length put changes nothing
                o_op.kind = OP_PUT;
                w_keep    = (w_bits != '0);
            end
            CMD_FLUSH: begin
                o_op.kind = OP_FLUSH;
                w_keep    = 1'b1;
            end
            CMD_CLEAR: begin
                o_op.kind = OP_CLEAR;
                w_keep    = 1'b1;
            end
            default: begin
                o_op.kind = OP_PUT;
                w_keep    = 1'b0;
            end
        endcase

        o_op_push = i_push && !i_full && w_keep;
    end

endmodule

// File: rtl/bp_op_queue.sv
// ----------------------------------------------------------------------------
// bp_op_queue
// two-entry queue of decoded operations between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bp_op_queue
    import bp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_op       i_op,
    input  logic      i_pop,
    output t_op       o_op,
    output t_q_status o_status
);

    t_op        r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
        o_op           = r_mem[r_rd_ptr];
        o_status.full  = (r_count == 2'd2);
        o_status.empty = (r_count == 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// File: rtl/bp_back.sv
// ----------------------------------------------------------------------------
// bp_back
// packs operations into the word in progress and queues finished words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bp_back
    import bp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_op_valid,
    input  t_op                  i_op,
    output logic                 o_op_pop,
    input  logic                 i_out_pop,
    output logic [WORD_BITS-1:0] o_word,
    output t_back_status         o_status
);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;
    logic [CNT_W-1:0]     r_free;
    logic [CNT_W-1:0]     n_free;

    logic [WORD_BITS-1:0] r_out_mem [2];
    logic                 r_out_wr;
    logic                 r_out_rd;
    logic [1:0]           r_out_count;
    logic [1:0]           n_out_count;

    logic                 w_overflow;
    logic                 w_emit;
    logic                 w_take;
    logic                 w_out_push;
    logic                 w_out_pop;
    logic [CNT_W-1:0]     w_over;
    logic [CNT_W-1:0]     w_free_put;
    logic [WORD_BITS-1:0] w_emit_word;

    function automatic logic [WORD_BITS-1:0] byte_swap(input logic [WORD_BITS-1:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    always_comb begin
        w_overflow = (i_op.kind == OP_PUT) && (i_op.bits > r_free);
        w_emit     = (i_op.kind == OP_FLUSH) || w_overflow;
        w_take     = i_op_valid && (!w_emit || (r_out_count != 2'd2));
        w_out_push = w_take && w_emit;
        w_out_pop  = i_out_pop && (r_out_count != 2'd0);
        w_over     = i_op.bits - r_free;

        if (w_overflow) begin
            w_free_put  = CNT_W'(WORD_BITS) - w_over;
            w_emit_word = r_word | (i_op.code >> w_over);
        end else begin
            w_free_put  = r_free - i_op.bits;
            w_emit_word = r_word;
        end

        n_word = r_word;
        n_free = r_free;
        if (w_take) begin
            case (i_op.kind) inside
                OP_PUT: begin
                    n_free = w_free_put;
                    n_word = (w_overflow ? '0 : r_word) | (i_op.code << w_free_put);
                end
                OP_FLUSH, OP_CLEAR: begin
                    n_free = CNT_W'(WORD_BITS);
                    n_word = '0;
                end
                default: begin
                    n_free = r_free;
                    n_word = r_word;
                end
            endcase
        end

        n_out_count = r_out_count;
        if (w_out_push && !w_out_pop) begin
            n_out_count = r_out_count + 2'd1;
        end else if (!w_out_push && w_out_pop) begin
            n_out_count = r_out_count - 2'd1;
        end

        o_op_pop           = w_take;
        o_word             = r_out_mem[r_out_rd];
        o_status.empty     = (r_out_count == 2'd0);
        o_status.out_count = r_out_count;
        o_status.out_push  = w_out_push;
        o_status.free_bits = r_free;
    end

    always_ff @(posedge i_clk) begin
        if (w_out_push) begin
            r_out_mem[r_out_wr] <= byte_swap(w_emit_word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_free      <= CNT_W'(WORD_BITS);
            r_out_wr    <= 1'b0;
            r_out_rd    <= 1'b0;
            r_out_count <= 2'd0;
        end else begin
            r_word      <= n_word;
            r_free      <= n_free;
            r_out_count <= n_out_count;
            if (w_out_push) begin
                r_out_wr <= ~r_out_wr;
            end
            if (w_out_pop) begin
                r_out_rd <= ~r_out_rd;
            end
        end
    end

endmodule

// File: rtl/msb_first_bit_packer_top.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer_top: packs 0..32-bit codes msb first into 32-bit words
// path: op queue, back, then result queue, from which the word can be popped
// throughput: one transfer per cycle in while not full, one word per cycle out
// reset: synchronous, clears both queues and restarts the word with 32 free bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "msb_first_bit_packer_top_assert.svh"

module msb_first_bit_packer_top
    import bp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input queue side
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           i_command,
    input  logic [CNT_W-1:0]     i_bit_count,
    input  logic [WORD_BITS-1:0] i_code_bits,
    // result queue side
    output logic                 empty,
    input  logic                 pop,
    output logic [WORD_BITS-1:0] o_packed_word
);

    // decoded operation from the front
    t_op          w_front_op;
    logic         w_front_push;
    // head of the operation queue
    t_op          w_queue_op;
    t_q_status    w_queue_st;
    logic         w_back_pop;
    // back status: result queue and packer state
    t_back_status w_back_st;

    // front: saturates the count, masks stray code bits, drops no-op items
    bp_front u_front (
        .i_push      (push),
        .i_full      (w_queue_st.full),
        .i_command   (i_command),
        .i_bit_count (i_bit_count),
        .i_code_bits (i_code_bits),
        .o_op_push   (w_front_push),
        .o_op        (w_front_op)
    );

    // short queue that lets front and back stall independently
    bp_op_queue u_op_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_front_push),
        .i_op     (w_front_op),
        .i_pop    (w_back_pop),
        .o_op     (w_queue_op),
        .o_status (w_queue_st)
    );

    // back: one operation per cycle, stalls only when a word must go out
    // and the result queue is full
    bp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!w_queue_st.empty),
        .i_op       (w_queue_op),
        .o_op_pop   (w_back_pop),
        .i_out_pop  (pop),
        .o_word     (o_packed_word),
        .o_status   (w_back_st)
    );

    // a transfer is refused only while the operation queue is full
    assign full  = w_queue_st.full;
    assign empty = w_back_st.empty;

    // free bit count stays within a word
    `BP_ASSERT_IMP(a_free_range, i_clk, i_rst_n, 1'b1, w_back_st.free_bits <= CNT_W'(WORD_BITS))
    // reset leaves both sides idle
    `BP_ASSERT_NXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, empty && !full)
    // a pop without a new word shrinks the result queue by one
    `BP_ASSERT_NXT(a_pop_count, i_clk, i_rst_n, pop && !empty && !w_back_st.out_push,
                   w_back_st.out_count == $past(w_back_st.out_count) - 2'd1)

endmodule
